// ----- rtl/hrlp_pkg.sv -----
`default_nettype none

package hrlp_pkg;

	localparam int FIELD_BUFFER_SIZE_DEF = 1024;

	localparam int ITEMS_MAX = 3;

	typedef enum logic [2:0] {
		PH_METHOD = 3'd0,
		PH_GAP    = 3'd1,
		PH_PATH   = 3'd2,
		PH_QUERY  = 3'd3,
		PH_AFTER  = 3'd4,
		PH_DONE   = 3'd5,
		PH_CUT    = 3'd6
	} phase_t;

	typedef enum logic [1:0] {
		SL_NONE = 2'd0,
		SL_OK   = 2'd1,
		SL_BAD  = 2'd2
	} slash_t;

	localparam logic [1:0] KIND_NAME   = 2'd0;
	localparam logic [1:0] KIND_QUERY  = 2'd1;
	localparam logic [1:0] KIND_STATUS = 2'd2;

	localparam logic [7:0] ST_OK     = 8'd0;
	localparam logic [7:0] ST_BAD    = 8'd1;
	localparam logic [7:0] ST_METHOD = 8'd2;
	localparam logic [7:0] ST_NAME   = 8'd3;
	localparam logic [7:0] ST_QUERY  = 8'd4;

	typedef struct packed {
		logic [1:0] kind;
		logic [7:0] value;
		logic       last;
	} item_t;

	typedef struct packed {
		phase_t     phase;
		logic [1:0] mcnt;
		logic       mbad;
		logic [1:0] esc;
		logic [7:0] held;
		slash_t     slash;
		logic       name_ended;
	} core_state_t;

endpackage

`default_nettype wire

// ----- rtl/hrlp_step.sv -----
`default_nettype none

module hrlp_step import hrlp_pkg::*; #(
	parameter int FIELD_BUFFER_SIZE = FIELD_BUFFER_SIZE_DEF,
	localparam int LW = $clog2(FIELD_BUFFER_SIZE + 1)
) (
	input  core_state_t              st,
	input  logic [LW-1:0]            name_len,
	input  logic [LW-1:0]            query_len,
	input  logic [7:0]               data,
	input  logic                     restart,
	output core_state_t              st_nxt,
	output logic [LW-1:0]            name_len_nxt,
	output logic [LW-1:0]            query_len_nxt,
	output item_t [ITEMS_MAX-1:0]    items,
	output logic [1:0]               count
);

	localparam logic [LW-1:0] LEN_MAX = LW'(FIELD_BUFFER_SIZE);
	localparam logic [LW-1:0] LEN_LIM = LW'(FIELD_BUFFER_SIZE - 1);

	localparam logic [7:0] CH_NUL     = 8'h00;
	localparam logic [7:0] CH_TAB     = 8'h09;
	localparam logic [7:0] CH_LF      = 8'h0a;
	localparam logic [7:0] CH_CR      = 8'h0d;
	localparam logic [7:0] CH_SPACE   = 8'h20;
	localparam logic [7:0] CH_PERCENT = 8'h25;
	localparam logic [7:0] CH_SLASH   = 8'h2f;
	localparam logic [7:0] CH_QMARK   = 8'h3f;

	typedef struct packed {
		core_state_t           s;
		logic [LW-1:0]         nl;
		logic [LW-1:0]         ql;
		item_t [ITEMS_MAX-1:0] it;
		logic [1:0]            n;
	} work_t;

	function automatic logic is_hex(input logic [7:0] c);
		return (c >= 8'h30 && c <= 8'h39) || (c >= 8'h61 && c <= 8'h66) ||
			(c >= 8'h41 && c <= 8'h46);
	endfunction

	function automatic logic [3:0] hex_val(input logic [7:0] c);
		logic [7:0] v;
		v = 8'd0;
		if (c >= 8'h30 && c <= 8'h39) begin
			v = c - 8'h30;
		end else if (c >= 8'h61 && c <= 8'h66) begin
			v = c - 8'h57;
		end else if (c >= 8'h41 && c <= 8'h46) begin
			v = c - 8'h37;
		end
		return v[3:0];
	endfunction

	function automatic logic [7:0] get_char(input logic [1:0] idx);
		logic [7:0] r;
		case (idx)
			2'd0:    r = 8'h67;
			2'd1:    r = 8'h65;
			2'd2:    r = 8'h74;
			default: r = 8'h00;
		endcase
		return r;
	endfunction

	function automatic logic method_ok(input work_t w);
		return (w.s.mcnt == 2'd3) && !w.s.mbad;
	endfunction

	function automatic work_t put(input work_t w, input logic [1:0] kind,
			input logic [7:0] value, input logic last);
		work_t r;
		r = w;
		if (r.n < 2'(ITEMS_MAX)) begin
			r.it[r.n].kind  = kind;
			r.it[r.n].value = value;
			r.it[r.n].last  = last;
			r.n = r.n + 2'd1;
		end
		return r;
	endfunction

	function automatic work_t dec(input work_t w, input logic [7:0] b);
		work_t r;
		r = w;
		if (r.s.slash == SL_NONE) begin
			r.s.slash = (b == CH_SLASH) ? SL_OK : SL_BAD;
		end else if (r.s.slash == SL_OK && !r.s.name_ended) begin
			if (b == CH_NUL) begin
				r.s.name_ended = 1'b1;
			end else begin
				if (method_ok(r)) begin
					r = put(r, KIND_NAME, b, 1'b0);
				end
				if (r.nl < LEN_MAX) begin
					r.nl = r.nl + LW'(1);
				end
			end
		end
		return r;
	endfunction

	function automatic work_t path_byte(input work_t w, input logic [7:0] c);
		work_t r;
		logic  done;
		r = w;
		done = 1'b0;
		if (r.s.esc == 2'd1) begin
			if (is_hex(c)) begin
				r.s.held = c;
				r.s.esc = 2'd2;
				done = 1'b1;
			end else begin
				r = dec(r, CH_PERCENT);
				r.s.esc = 2'd0;
			end
		end else if (r.s.esc == 2'd2) begin
			r.s.esc = 2'd0;
			if (is_hex(c)) begin
				r = dec(r, {hex_val(r.s.held), hex_val(c)});
				done = 1'b1;
			end else begin
				r = dec(r, CH_PERCENT);
				r = dec(r, r.s.held);
			end
		end
		if (!done) begin
			if (c == CH_PERCENT) begin
				r.s.esc = 2'd1;
			end else begin
				r = dec(r, c);
			end
		end
		return r;
	endfunction

	function automatic work_t flush(input work_t w);
		work_t r;
		r = w;
		if (r.s.esc != 2'd0) begin
			r = dec(r, CH_PERCENT);
		end
		if (r.s.esc == 2'd2) begin
			r = dec(r, r.s.held);
		end
		r.s.esc = 2'd0;
		return r;
	endfunction

	function automatic work_t bad_request(input work_t w);
		work_t r;
		r = put(w, KIND_STATUS, ST_BAD, 1'b1);
		r.s.phase = PH_DONE;
		return r;
	endfunction

	function automatic work_t final_status(input work_t w);
		work_t      r;
		logic [7:0] s;
		r = w;
		s = ST_OK;
		if (!method_ok(r)) begin
			s = ST_METHOD;
		end else if (r.s.slash != SL_OK || r.nl >= LEN_LIM) begin
			s = ST_NAME;
		end else if (r.ql >= LEN_LIM) begin
			s = ST_QUERY;
		end
		r = put(r, KIND_STATUS, s, 1'b1);
		r.s.phase = PH_DONE;
		return r;
	endfunction

	logic  eol;
	logic  blank;
	logic  [7:0] lc;
	work_t w;

	assign eol   = (data == CH_CR) || (data == CH_LF);
	assign blank = (data == CH_SPACE) || (data == CH_TAB);
	assign lc    = (data >= 8'h41 && data <= 8'h5a) ? data + 8'h20 : data;

	always_comb begin
		w    = '0;
		w.s  = st;
		w.nl = name_len;
		w.ql = query_len;
		if (restart) begin
			w.s.phase      = PH_METHOD;
			w.s.mcnt       = 2'd0;
			w.s.mbad       = 1'b0;
			w.s.esc        = 2'd0;
			w.s.held       = 8'd0;
			w.s.slash      = SL_NONE;
			w.s.name_ended = 1'b0;
			w.nl           = '0;
			w.ql           = '0;
		end
		case (w.s.phase)
			PH_METHOD: begin
				if (eol) begin
					w = bad_request(w);
				end else if (data == CH_NUL) begin
					w.s.phase = PH_CUT;
				end else if (blank) begin
					w.s.phase = PH_GAP;
				end else if (w.s.mcnt == 2'd3 || lc != get_char(w.s.mcnt)) begin
					w.s.mbad = 1'b1;
				end else begin
					w.s.mcnt = w.s.mcnt + 2'd1;
				end
			end
			PH_GAP, PH_PATH: begin
				if (eol) begin
					if (w.s.phase == PH_PATH) begin
						w = flush(w);
					end
					w = bad_request(w);
				end else if (!(w.s.phase == PH_GAP && blank)) begin
					w.s.phase = PH_PATH;
					if (data == CH_NUL) begin
						w.s.phase = PH_CUT;
					end else if (blank) begin
						w = flush(w);
						w.s.phase = PH_AFTER;
					end else if (data == CH_QMARK) begin
						w = flush(w);
						if (w.s.slash == SL_NONE) begin
							w.s.slash = SL_BAD;
						end
						w.s.phase = PH_QUERY;
					end else begin
						w = path_byte(w, data);
					end
				end
			end
			PH_QUERY: begin
				if (eol) begin
					w = bad_request(w);
				end else if (data == CH_NUL) begin
					w.s.phase = PH_CUT;
				end else if (blank) begin
					w.s.phase = PH_AFTER;
				end else begin
					if (method_ok(w) && w.s.slash == SL_OK) begin
						w = put(w, KIND_QUERY, data, 1'b0);
					end
					if (w.ql < LEN_MAX) begin
						w.ql = w.ql + LW'(1);
					end
				end
			end
			PH_AFTER: begin
				if (eol) begin
					if (w.s.slash == SL_NONE) begin
						w.s.slash = SL_BAD;
					end
					w = final_status(w);
				end
			end
			PH_CUT: begin
				if (eol) begin
					w = bad_request(w);
				end
			end
			default: begin
			end
		endcase
	end

	assign st_nxt        = w.s;
	assign name_len_nxt  = w.nl;
	assign query_len_nxt = w.ql;
	assign items         = w.it;
	assign count         = w.n;

endmodule

`default_nettype wire

// ----- rtl/http_request_line_parser_core.sv -----
// Flow: an accepted word is held in the input register and parsed into the result
// bundle register once the output side is free; its first result is then offered.
// Throughput: one word per cycle while no word yields more than one result and m_tready
// is high; a word yielding two or three results stalls input until the last one is taken.
// Reset: asynchronous, active low; clears parse state, length counters and both stages.
`default_nettype none

module http_request_line_parser_core import hrlp_pkg::*; #(
	parameter int FIELD_BUFFER_SIZE = FIELD_BUFFER_SIZE_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [7:0]  s_tdata,   // [7:0] request_byte
	input  wire logic        s_tuser,   // [0] new_request
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [7:0]       m_tdata,   // [7:0] item_value
	output logic [1:0]       m_tuser,   // [1:0] item_kind
	output logic             m_tlast
);

	localparam int LW = $clog2(FIELD_BUFFER_SIZE + 1);

	logic                  valid_s1;
	logic [7:0]            data_s1;
	logic                  restart_s1;

	item_t [ITEMS_MAX-1:0] items_s2;
	logic [1:0]            cnt_s2;
	logic [1:0]            idx_s2;

	core_state_t           st_q;
	logic [LW-1:0]         name_len_q;
	logic [LW-1:0]         query_len_q;

	core_state_t           st_nxt;
	logic [LW-1:0]         name_len_nxt;
	logic [LW-1:0]         query_len_nxt;
	item_t [ITEMS_MAX-1:0] items_nxt;
	logic [1:0]            cnt_nxt;

	logic                  take;
	logic                  last_take;
	logic                  slot_free;
	logic                  proc;
	item_t                 cur;

	hrlp_step #(
		.FIELD_BUFFER_SIZE(FIELD_BUFFER_SIZE)
	) u_step (
		.st            (st_q),
		.name_len      (name_len_q),
		.query_len     (query_len_q),
		.data          (data_s1),
		.restart       (restart_s1),
		.st_nxt        (st_nxt),
		.name_len_nxt  (name_len_nxt),
		.query_len_nxt (query_len_nxt),
		.items         (items_nxt),
		.count         (cnt_nxt)
	);

	assign cur       = items_s2[idx_s2];
	assign m_tvalid  = (idx_s2 != cnt_s2);
	assign m_tdata   = cur.value;
	assign m_tuser   = cur.kind;
	assign m_tlast   = cur.last;

	assign take      = m_tvalid && m_tready;
	assign last_take = take && ((idx_s2 + 2'd1) == cnt_s2);
	assign slot_free = !m_tvalid || last_take;
	assign proc      = valid_s1 && slot_free;
	assign s_tready  = !valid_s1 || proc;

	// input word register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			data_s1    <= s_tdata;
			restart_s1 <= s_tuser;
		end
	end

	// parse state and result bundle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q.phase      <= PH_METHOD;
			st_q.mcnt       <= 2'd0;
			st_q.mbad       <= 1'b0;
			st_q.esc        <= 2'd0;
			st_q.held       <= 8'd0;
			st_q.slash      <= SL_NONE;
			st_q.name_ended <= 1'b0;
			name_len_q      <= '0;
			query_len_q     <= '0;
			cnt_s2          <= 2'd0;
			idx_s2          <= 2'd0;
		end else if (proc) begin
			st_q        <= st_nxt;
			name_len_q  <= name_len_nxt;
			query_len_q <= query_len_nxt;
			cnt_s2      <= cnt_nxt;
			idx_s2      <= 2'd0;
		end else if (take) begin
			idx_s2 <= idx_s2 + 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (proc) begin
			items_s2 <= items_nxt;
		end
	end

	a_idx_bound: assert property (@(posedge clk) disable iff (!arst_n)
		idx_s2 <= cnt_s2)
		else $error("result index beyond bundle count");

	a_last_is_status: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tlast |-> m_tuser == KIND_STATUS)
		else $error("last flag on a byte word");

	a_status_ends_bundle: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tlast |-> (idx_s2 + 2'd1) == cnt_s2)
		else $error("status word not at end of bundle");

	a_done_silent: assert property (@(posedge clk) disable iff (!arst_n)
		proc && st_q.phase == PH_DONE && !restart_s1 |=> !m_tvalid)
		else $error("result after request finished");

endmodule

`default_nettype wire

// ----- bench/http_request_line_parser_core_test.sv -----
module http_request_line_parser_core_test;
	import hrlp_pkg::*;

	localparam int CYCLE_LIMIT = 1000000;
	localparam int FIELD_LIMIT = FIELD_BUFFER_SIZE_DEF;
	localparam int DRAIN_CYCLES = 20;

	localparam logic [7:0] CH_NUL   = 8'h00;
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_LF    = 8'h0A;
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_PCT   = 8'h25;
	localparam logic [7:0] CH_SLASH = 8'h2F;
	localparam logic [7:0] CH_QMARK = 8'h3F;

	localparam logic [1:0] ESC_IDLE = 2'd0;
	localparam logic [1:0] ESC_PCT  = 2'd1;
	localparam logic [1:0] ESC_HEX  = 2'd2;

	typedef struct {
		logic [7:0] data;
		logic       start;
	} word_t;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       s_tvalid = 1'b0;
	logic       s_tready;
	logic [7:0] s_tdata = 8'h00;
	logic       s_tuser = 1'b0;
	logic       m_tvalid;
	logic       m_tready = 1'b0;
	logic [7:0] m_tdata;
	logic [1:0] m_tuser;
	logic       m_tlast;

	http_request_line_parser_core u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

	word_t  pending_words[$];
	item_t  predicted_outputs[$];
	logic   start_next = 1'b0;
	logic   draining = 1'b0;
	int     send_gap = 0;
	int     recv_stall = 0;
	logic   send_quiet = 1'b0;
	logic   recv_quiet = 1'b0;
	int     mismatches = 0;
	int     cycle_count = 0;

	phase_t      parser_phase = PH_METHOD;
	logic [1:0]  get_count = 2'd0;
	logic        get_mismatch = 1'b0;
	logic [1:0]  escape_step = ESC_IDLE;
	logic [7:0]  hex_hold = 8'h00;
	slash_t      slash_state = SL_NONE;
	logic        name_done = 1'b0;
	logic [10:0] name_len = '0;
	logic [10:0] query_len = '0;

	initial begin
		forever #2 clk = ~clk;
	end

	function automatic void clear_parser();
		parser_phase = PH_METHOD;
		get_count = 2'd0;
		get_mismatch = 1'b0;
		escape_step = ESC_IDLE;
		hex_hold = 8'h00;
		slash_state = SL_NONE;
		name_done = 1'b0;
		name_len = '0;
		query_len = '0;
	endfunction

	function automatic logic is_hex_digit(input logic [7:0] c);
		return (c >= "0" && c <= "9") || (c >= "a" && c <= "f") || (c >= "A" && c <= "F");
	endfunction

	function automatic logic [3:0] hex_nibble(input logic [7:0] c);
		if (c >= "0" && c <= "9")
			return 4'(c - "0");
		if (c >= "a" && c <= "f")
			return 4'(c - "a" + 8'd10);
		return 4'(c - "A" + 8'd10);
	endfunction

	function automatic logic [7:0] get_letter(input logic [1:0] idx);
		case (idx)
			2'd0: return "g";
			2'd1: return "e";
			default: return "t";
		endcase
	endfunction

	function automatic logic method_is_get();
		return get_count == 2'd3 && !get_mismatch;
	endfunction

	function automatic void expect_out(input logic [1:0] kind, input logic [7:0] value,
			input logic last);
		item_t it;
		it.kind = kind;
		it.value = value;
		it.last = last;
		predicted_outputs.push_back(it);
	endfunction

	function automatic void expect_bad_request();
		expect_out(KIND_STATUS, ST_BAD, 1'b1);
		parser_phase = PH_DONE;
	endfunction

	function automatic void expect_status();
		logic [7:0] st;
		if (!method_is_get())
			st = ST_METHOD;
		else if (slash_state != SL_OK || name_len >= FIELD_LIMIT - 1)
			st = ST_NAME;
		else if (query_len >= FIELD_LIMIT - 1)
			st = ST_QUERY;
		else
			st = ST_OK;
		expect_out(KIND_STATUS, st, 1'b1);
		parser_phase = PH_DONE;
	endfunction

	function automatic void take_method_char(input logic [7:0] c);
		logic [7:0] lc;
		lc = (c >= "A" && c <= "Z") ? c + 8'd32 : c;
		if (get_count == 2'd3 || lc != get_letter(get_count))
			get_mismatch = 1'b1;
		else
			get_count = get_count + 2'd1;
	endfunction

	function automatic void take_decoded(input logic [7:0] b);
		if (slash_state == SL_NONE) begin
			slash_state = (b == CH_SLASH) ? SL_OK : SL_BAD;
			return;
		end
		if (slash_state != SL_OK || name_done)
			return;
		if (b == CH_NUL) begin
			name_done = 1'b1;
			return;
		end
		if (method_is_get())
			expect_out(KIND_NAME, b, 1'b0);
		if (name_len < FIELD_LIMIT)
			name_len = name_len + 11'd1;
	endfunction

	function automatic void take_path_char(input logic [7:0] c);
		if (escape_step == ESC_PCT) begin
			if (is_hex_digit(c)) begin
				hex_hold = c;
				escape_step = ESC_HEX;
				return;
			end
			take_decoded(CH_PCT);
			escape_step = ESC_IDLE;
		end else if (escape_step == ESC_HEX) begin
			escape_step = ESC_IDLE;
			if (is_hex_digit(c)) begin
				take_decoded({hex_nibble(hex_hold), hex_nibble(c)});
				return;
			end
			take_decoded(CH_PCT);
			take_decoded(hex_hold);
		end
		if (c == CH_PCT)
			escape_step = ESC_PCT;
		else
			take_decoded(c);
	endfunction

	function automatic void flush_escape();
		if (escape_step != ESC_IDLE)
			take_decoded(CH_PCT);
		if (escape_step == ESC_HEX)
			take_decoded(hex_hold);
		escape_step = ESC_IDLE;
	endfunction

	function automatic void target_char(input logic [7:0] c);
		if (c == CH_CR || c == CH_LF) begin
			flush_escape();
			expect_bad_request();
		end else if (c == CH_NUL) begin
			parser_phase = PH_CUT;
		end else if (c == CH_SPACE || c == CH_TAB) begin
			flush_escape();
			parser_phase = PH_AFTER;
		end else if (c == CH_QMARK) begin
			flush_escape();
			if (slash_state == SL_NONE)
				slash_state = SL_BAD;
			parser_phase = PH_QUERY;
		end else begin
			take_path_char(c);
		end
	endfunction

	function automatic void parse_word(input logic [7:0] c, input logic start);
		logic eol;
		logic blank;
		eol = (c == CH_CR) || (c == CH_LF);
		blank = (c == CH_SPACE) || (c == CH_TAB);
		if (start)
			clear_parser();
		case (parser_phase)
			PH_METHOD: begin
				if (eol)
					expect_bad_request();
				else if (c == CH_NUL)
					parser_phase = PH_CUT;
				else if (blank)
					parser_phase = PH_GAP;
				else
					take_method_char(c);
			end
			PH_GAP: begin
				if (eol) begin
					expect_bad_request();
				end else if (!blank) begin
					parser_phase = PH_PATH;
					target_char(c);
				end
			end
			PH_PATH: begin
				target_char(c);
			end
			PH_QUERY: begin
				if (eol) begin
					expect_bad_request();
				end else if (c == CH_NUL) begin
					parser_phase = PH_CUT;
				end else if (blank) begin
					parser_phase = PH_AFTER;
				end else begin
					if (method_is_get() && slash_state == SL_OK)
						expect_out(KIND_QUERY, c, 1'b0);
					if (query_len < FIELD_LIMIT)
						query_len = query_len + 11'd1;
				end
			end
			PH_AFTER: begin
				if (eol) begin
					if (slash_state == SL_NONE)
						slash_state = SL_BAD;
					expect_status();
				end
			end
			PH_CUT: begin
				if (eol)
					expect_bad_request();
			end
			default: begin
			end
		endcase
	endfunction

	function automatic void check_output(input logic [1:0] kind, input logic [7:0] value,
			input logic last);
		item_t want;
		if (predicted_outputs.size() == 0) begin
			mismatches++;
			if (mismatches <= 10)
				$display("unexpected word: kind %0d value %02h last %0d", kind, value, last);
			return;
		end
		want = predicted_outputs.pop_front();
		if (kind !== want.kind || value !== want.value || last !== want.last) begin
			mismatches++;
			if (mismatches <= 10)
				$display("mismatch: expected kind %0d value %02h last %0d, got kind %0d value %02h last %0d",
					want.kind, want.value, want.last, kind, value, last);
		end
	endfunction

	function automatic int pick_gap(input logic quiet);
		int r;
		r = $urandom_range(0, 99);
		if (quiet || r < 60)
			return 0;
		if (r < 93)
			return $urandom_range(1, 3);
		return $urandom_range(8, 30);
	endfunction

	function automatic logic [7:0] hex_char();
		string digits;
		digits = "0123456789abcdefABCDEF";
		return digits[$urandom_range(0, 21)];
	endfunction

	function automatic logic [7:0] safe_char(input logic marks_ok);
		string common;
		logic [7:0] c;
		common = "abcdefxyzABZ0189-._~/";
		if ($urandom_range(0, 9) < 7)
			return common[$urandom_range(0, common.len() - 1)];
		do
			c = 8'($urandom_range(1, 255));
		while (c == CH_TAB || c == CH_LF || c == CH_CR || c == CH_SPACE ||
			(!marks_ok && (c == CH_PCT || c == CH_QMARK)));
		return c;
	endfunction

	task automatic put_byte(input logic [7:0] b);
		word_t w;
		w.data = b;
		w.start = start_next;
		start_next = 1'b0;
		pending_words.push_back(w);
	endtask

	task automatic put_text(input string s);
		for (int i = 0; i < s.len(); i++)
			put_byte(s[i]);
	endtask

	task automatic put_eol();
		put_byte($urandom_range(0, 1) ? CH_CR : CH_LF);
	endtask

	task automatic put_blanks(input int lo);
		repeat ($urandom_range(lo, 3))
			put_byte($urandom_range(0, 1) ? CH_SPACE : CH_TAB);
	endtask

	task automatic put_method();
		string name;
		logic [7:0] c;
		case ($urandom_range(0, 11))
			7: name = "post";
			8: name = "ge";
			9: name = "gets";
			10: name = "";
			11: name = "gxt";
			default: name = "get";
		endcase
		for (int i = 0; i < name.len(); i++) begin
			c = name[i];
			put_byte($urandom_range(0, 1) ? c - 8'd32 : c);
		end
	endtask

	task automatic put_path();
		int r;
		r = $urandom_range(0, 19);
		if (r < 15)
			put_byte(CH_SLASH);
		else if (r < 17)
			put_text($urandom_range(0, 1) ? "%2f" : "%2F");
		else if (r == 17)
			put_byte(safe_char(1'b0));
		else if (r == 18)
			put_text("%41");
		repeat ($urandom_range(0, 8)) begin
			r = $urandom_range(0, 19);
			if (r < 12) begin
				put_byte(safe_char(1'b0));
			end else if (r < 15) begin
				put_byte(CH_PCT);
				put_byte(hex_char());
				put_byte(hex_char());
			end else if (r == 15) begin
				put_text("%00");
			end else if (r == 16) begin
				put_byte(CH_PCT);
				put_byte(safe_char(1'b0));
			end else if (r == 17) begin
				put_byte(CH_PCT);
				put_byte(hex_char());
				put_byte(safe_char(1'b0));
			end else if (r == 18) begin
				put_byte(CH_PCT);
				put_byte(hex_char());
			end else begin
				put_byte(CH_PCT);
			end
		end
	endtask

	task automatic put_request();
		int r;
		start_next = 1'b1;
		put_method();
		put_blanks(1);
		put_path();
		if ($urandom_range(0, 9) < 6) begin
			put_byte(CH_QMARK);
			repeat ($urandom_range(0, 8))
				put_byte(safe_char(1'b1));
		end
		r = $urandom_range(0, 19);
		if (r < 15) begin
			put_blanks(1);
			if ($urandom_range(0, 3) != 0)
				put_text("HTTP/1.1");
			put_eol();
		end else if (r < 17) begin
			put_eol();
		end else if (r < 19) begin
			put_byte(CH_NUL);
			put_text("x y");
			put_eol();
		end
		if ($urandom_range(0, 1)) begin
			put_text("Host: a");
			put_eol();
		end
	endtask

	task automatic put_noise();
		start_next = 1'b1;
		repeat ($urandom_range(1, 12)) begin
			if ($urandom_range(0, 5) == 0)
				start_next = 1'b1;
			put_byte(8'($urandom_range(0, 255)));
		end
	endtask

	always @(posedge clk) begin
		word_t w;
		if (!arst_n) begin
			s_tvalid <= 1'b0;
		end else begin
			if (s_tvalid && s_tready) begin
				parse_word(s_tdata, s_tuser);
				if ($urandom_range(0, 79) == 0)
					send_quiet = !send_quiet;
			end
			if (!s_tvalid || s_tready) begin
				if (send_gap > 0) begin
					send_gap = send_gap - 1;
					s_tvalid <= 1'b0;
				end else if (pending_words.size() > 0) begin
					w = pending_words.pop_front();
					s_tvalid <= 1'b1;
					s_tdata <= w.data;
					s_tuser <= w.start;
					send_gap = pick_gap(send_quiet);
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else begin
			if (m_tvalid && m_tready) begin
				check_output(m_tuser, m_tdata, m_tlast);
				if ($urandom_range(0, 79) == 0)
					recv_quiet = !recv_quiet;
			end
			if (draining) begin
				m_tready <= 1'b1;
			end else begin
				if (recv_stall == 0 && ((m_tvalid && m_tready) || $urandom_range(0, 15) == 0))
					recv_stall = pick_gap(recv_quiet);
				if (recv_stall > 0) begin
					recv_stall = recv_stall - 1;
					m_tready <= 1'b0;
				end else begin
					m_tready <= 1'b1;
				end
			end
		end
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("TEST FAILED");
			$finish;
		end
	end

	initial begin
		start_next = 1'b1;
		put_text("gEt /%4a%?z");
		put_byte(CH_TAB);
		put_byte(CH_LF);
		start_next = 1'b1;
		put_byte(CH_NUL);
		put_byte(CH_CR);
		start_next = 1'b1;
		put_byte(8'hFF);
		put_byte(CH_CR);
		start_next = 1'b1;
		put_byte(CH_TAB);
		put_text("/%4g");
		put_byte(CH_CR);

		while (pending_words.size() < 150) begin
			if ($urandom_range(0, 9) == 0)
				put_noise();
			else
				put_request();
		end

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		while (pending_words.size() > 0 || s_tvalid)
			@(posedge clk);
		draining <= 1'b1;
		while (predicted_outputs.size() > 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0 && predicted_outputs.size() == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule
